>>> design/plma_pkg.sv
// Shared types, widths and codes for the per-label mean accumulator.
`default_nettype none
package plma_pkg;

	// Default sizing
	localparam int NUM_LABELS_DEF = 1024;
	localparam int PROB_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 24;

	// Fixed port widths
	localparam int FUNC_W   = 2;
	localparam int LABEL_W  = 16;
	localparam int PROB_W   = 16;
	localparam int MEAN_W   = 16;
	localparam int CNTOUT_W = 24;
	localparam int STAT_W   = 2;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_we;
		logic load;
		logic exec;
		logic div_step;
		logic div_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic need_div;
		logic div_last;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> design/plma_ctrl.sv
// Controller state machine for the per-label mean accumulator.
`default_nettype none
module plma_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire plma_pkg::dp_stat_t stat,
	output plma_pkg::ctrl_cmd_t     cmd,
	output logic                    busy
);

	plma_pkg::state_t state_q;
	plma_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plma_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plma_pkg::S_CLEAR: begin
				if (stat.clr_last) state_d = plma_pkg::S_IDLE;
			end
			plma_pkg::S_IDLE: begin
				if (start) state_d = plma_pkg::S_EXEC;
			end
			plma_pkg::S_EXEC: begin
				state_d = stat.need_div ? plma_pkg::S_DIV : plma_pkg::S_IDLE;
			end
			plma_pkg::S_DIV: begin
				if (stat.div_last) state_d = plma_pkg::S_DONE;
			end
			plma_pkg::S_DONE: begin
				state_d = plma_pkg::S_IDLE;
			end
			default: begin
				state_d = plma_pkg::S_IDLE;
			end
		endcase
	end

	// Commands per state
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			plma_pkg::S_CLEAR: begin
				cmd.clr_we = 1'b1;
			end
			plma_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			plma_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			plma_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			plma_pkg::S_DONE: begin
				cmd.div_out = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/plma_dp.sv
// Datapath: label memory, accumulate update, shift-subtract divider, result registers.
`default_nettype none
module plma_dp #(
	parameter int NUM_LABELS = plma_pkg::NUM_LABELS_DEF,
	parameter int PROB_BITS  = plma_pkg::PROB_BITS_DEF,
	parameter int COUNT_BITS = plma_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire plma_pkg::ctrl_cmd_t               cmd,
	output plma_pkg::dp_stat_t                     stat,
	input  wire logic [plma_pkg::FUNC_W-1:0]       func,
	input  wire logic [plma_pkg::LABEL_W-1:0]      region_label,
	input  wire logic [plma_pkg::PROB_W-1:0]       probability,
	output logic                                   done,
	output logic [plma_pkg::MEAN_W-1:0]            mean_value,
	output logic [plma_pkg::CNTOUT_W-1:0]          pixel_count,
	output logic [plma_pkg::LABEL_W-1:0]           largest_label,
	output logic [plma_pkg::STAT_W-1:0]            status
);

	localparam int AW  = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
	localparam int SW  = COUNT_BITS + PROB_BITS;
	localparam int EW  = SW + COUNT_BITS;
	localparam int PW  = (PROB_BITS < plma_pkg::PROB_W) ? PROB_BITS : plma_pkg::PROB_W;
	localparam int DCW = $clog2(SW);
	localparam int CXW = (COUNT_BITS > plma_pkg::CNTOUT_W) ? COUNT_BITS : plma_pkg::CNTOUT_W;

	// Captured item
	logic [plma_pkg::FUNC_W-1:0]  func_q;
	logic [plma_pkg::LABEL_W-1:0] label_q;
	logic [PW-1:0]                prob_q;
	logic                         valid_q;
	logic [AW-1:0]                idx_q;

	// Label memory: {sum, count} per entry
	logic [EW-1:0] mem [NUM_LABELS];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;

	logic [AW-1:0]                clr_idx_q;
	logic [plma_pkg::LABEL_W-1:0] max_q;
	logic                         done_q;

	// Divider
	logic [COUNT_BITS-1:0] rem_q;
	logic [SW-1:0]         dvd_q;
	logic [DCW-1:0]        dcnt_q;
	logic [COUNT_BITS-1:0] div_cnt_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  trial_ge;
	logic [CXW-1:0]        cnt_x;

	// Result registers
	logic [plma_pkg::MEAN_W-1:0]   mean_q;
	logic [plma_pkg::CNTOUT_W-1:0] pcnt_q;
	logic [plma_pkg::LABEL_W-1:0]  largest_q;
	logic [plma_pkg::STAT_W-1:0]   status_q;

	logic                         in_valid;
	logic [AW-1:0]                in_idx;
	logic [SW-1:0]                rd_sum;
	logic [COUNT_BITS-1:0]        rd_cnt;
	logic                         cnt_sat;
	logic                         cnt_zero;
	logic [plma_pkg::LABEL_W-1:0] max_acc;
	logic [plma_pkg::LABEL_W-1:0] res_largest;
	logic [plma_pkg::STAT_W-1:0]  res_status;

	// Decode incoming label
	assign in_valid = (region_label != '0) &&
		(region_label <= plma_pkg::LABEL_W'(NUM_LABELS));
	assign in_idx = in_valid ? AW'(region_label - plma_pkg::LABEL_W'(1)) : '0;

	// Capture item on accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			label_q <= region_label;
			prob_q  <= probability[PW-1:0];
			valid_q <= in_valid;
			idx_q   <= in_idx;
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= mem[in_idx];
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

	assign rd_sum   = rd_q[EW-1:COUNT_BITS];
	assign rd_cnt   = rd_q[COUNT_BITS-1:0];
	assign cnt_sat  = &rd_cnt;
	assign cnt_zero = (rd_cnt == '0);

	// Write select: clearing pass, accumulate, or clear after read
	always_comb begin
		we = cmd.clr_we || (cmd.exec && valid_q &&
			(((func_q == plma_pkg::FUNC_ACCUM) && !cnt_sat) ||
			 ((func_q == plma_pkg::FUNC_READ) && !cnt_zero)));
		wa = cmd.clr_we ? clr_idx_q : idx_q;
		if (cmd.exec && (func_q == plma_pkg::FUNC_ACCUM)) begin
			wd = {rd_sum + SW'(prob_q), rd_cnt + COUNT_BITS'(1)};
		end else begin
			wd = '0;
		end
	end

	assign max_acc = (label_q > max_q) ? label_q : max_q;

	// Status toward the controller
	assign stat.clr_last = (clr_idx_q == AW'(NUM_LABELS - 1));
	assign stat.need_div = (func_q == plma_pkg::FUNC_READ) && valid_q && !cnt_zero;
	assign stat.div_last = (dcnt_q == DCW'(SW - 1));

	// Result of a single-pass item
	always_comb begin
		res_largest = max_q;
		res_status  = plma_pkg::STAT_OK;
		case (func_q)
			plma_pkg::FUNC_ACCUM: begin
				if (valid_q) begin
					res_largest = max_acc;
				end else begin
					res_status = plma_pkg::STAT_RANGE;
				end
			end
			plma_pkg::FUNC_READ: begin
				if (!valid_q) begin
					res_status = plma_pkg::STAT_RANGE;
				end else if (cnt_zero) begin
					res_status = plma_pkg::STAT_EMPTY;
				end
			end
			plma_pkg::FUNC_FRAME: begin
				res_largest = '0;
			end
			default: begin
				res_largest = max_q;
			end
		endcase
	end

	// Control registers: clear index, largest label, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			max_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (cmd.exec) begin
				if ((func_q == plma_pkg::FUNC_ACCUM) && valid_q) begin
					max_q <= max_acc;
				end else if (func_q == plma_pkg::FUNC_FRAME) begin
					max_q <= '0;
				end
			end
			done_q <= (cmd.exec && !stat.need_div) || cmd.div_out;
		end
	end

	// Restoring divide, one quotient bit per cycle
	assign trial    = {rem_q, dvd_q[SW-1]};
	assign diff     = trial - {1'b0, div_cnt_q};
	assign trial_ge = (trial >= {1'b0, div_cnt_q});

	always_ff @(posedge clk) begin
		if (cmd.exec && stat.need_div) begin
			rem_q     <= '0;
			dvd_q     <= rd_sum;
			dcnt_q    <= '0;
			div_cnt_q <= rd_cnt;
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dvd_q  <= {dvd_q[SW-2:0], trial_ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	assign cnt_x = CXW'(div_cnt_q);

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec && !stat.need_div) begin
			mean_q    <= '0;
			pcnt_q    <= '0;
			largest_q <= res_largest;
			status_q  <= res_status;
		end else if (cmd.div_out) begin
			mean_q    <= dvd_q[plma_pkg::MEAN_W-1:0];
			pcnt_q    <= cnt_x[plma_pkg::CNTOUT_W-1:0];
			largest_q <= max_q;
			status_q  <= plma_pkg::STAT_OK;
		end
	end

	assign done          = done_q;
	assign mean_value    = mean_q;
	assign pixel_count   = pcnt_q;
	assign largest_label = largest_q;
	assign status        = status_q;

endmodule
`default_nettype wire

>>> design/per_label_mean_accumulator_top.sv
// Top level of the per-label mean accumulator: controller plus datapath.
//
// Usage: present func, region_label and probability with start; the beat is
// taken at a rising edge where start is high and busy is low. Every item
// yields exactly one result beat: done is high for one cycle with
// mean_value, pixel_count, largest_label and status, and the receiver takes
// it at the end of that cycle (there is no back-pressure on results).
// Accumulate, new-frame, out-of-range and empty reads: accept leads to the
// EXEC state, done rises as the block leaves it and busy drops with it, so
// such an item is done before the next is taken; the EXEC state is set by
// the registered read of the label memory before its read-modify-write.
// Reads of a label with pixels: the shift-subtract divider yields one
// quotient bit per cycle over COUNT_BITS+PROB_BITS steps in the DIV state,
// so done rises after the EXEC, DIV and DONE states, and busy stays high
// until done is shown, so such a read ends before the next item is taken.
// Reset: after arst_n releases, the block zeroes the label memory one entry
// per cycle for NUM_LABELS cycles (1024 by default) with busy held high.
// The next item may be offered in the same cycle that done is shown.
`default_nettype none
module per_label_mean_accumulator_top #(
	parameter int NUM_LABELS = plma_pkg::NUM_LABELS_DEF,
	parameter int PROB_BITS  = plma_pkg::PROB_BITS_DEF,
	parameter int COUNT_BITS = plma_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [plma_pkg::FUNC_W-1:0]      func,
	input  wire logic [plma_pkg::LABEL_W-1:0]     region_label,
	input  wire logic [plma_pkg::PROB_W-1:0]      probability,
	output logic                                  done,
	output logic [plma_pkg::MEAN_W-1:0]           mean_value,
	output logic [plma_pkg::CNTOUT_W-1:0]         pixel_count,
	output logic [plma_pkg::LABEL_W-1:0]          largest_label,
	output logic [plma_pkg::STAT_W-1:0]           status
);

	plma_pkg::ctrl_cmd_t cmd;
	plma_pkg::dp_stat_t  stat;

	plma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	plma_dp #(
		.NUM_LABELS (NUM_LABELS),
		.PROB_BITS  (PROB_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.region_label  (region_label),
		.probability   (probability),
		.done          (done),
		.mean_value    (mean_value),
		.pixel_count   (pixel_count),
		.largest_label (largest_label),
		.status        (status)
	);

	// A result beat never overlaps work on an item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start work");

	// Non-ok results carry neither a mean nor a count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != plma_pkg::STAT_OK)) |->
			((mean_value == '0) && (pixel_count == '0)))
		else $error("error result with nonzero payload");

	// Divider runs only after a read that found pixels
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.div_step) |-> $past(cmd.exec && stat.need_div))
		else $error("divider started without a pending read");

endmodule
`default_nettype wire

>>> test/per_label_mean_accumulator_top_tb.sv
// Self-checking testbench for the per-label mean accumulator top level.
`timescale 1ns / 100ps
module per_label_mean_accumulator_top_tb;

	localparam int NUM_LBL    = plma_pkg::NUM_LABELS_DEF;
	localparam int CNT_BITS   = plma_pkg::COUNT_BITS_DEF;
	localparam logic [plma_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int RAND_ITEMS = 1630;
	localparam int POOL_SIZE  = 12;
	localparam int CYCLE_CAP  = 600000;
	localparam int DRAIN_WAIT = 60;

	typedef struct packed {
		logic [plma_pkg::FUNC_W-1:0]  func;
		logic [plma_pkg::LABEL_W-1:0] label;
		logic [plma_pkg::PROB_W-1:0]  prob;
	} pixel_cmd_t;

	typedef struct packed {
		logic [plma_pkg::MEAN_W-1:0]   mean;
		logic [plma_pkg::CNTOUT_W-1:0] count;
		logic [plma_pkg::LABEL_W-1:0]  largest;
		logic [plma_pkg::STAT_W-1:0]   status;
	} label_stat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic [plma_pkg::FUNC_W-1:0]   func         = plma_pkg::FUNC_ACCUM;
	logic [plma_pkg::LABEL_W-1:0]  region_label = '0;
	logic [plma_pkg::PROB_W-1:0]   probability  = '0;
	logic                          busy;
	logic                          done;
	logic [plma_pkg::MEAN_W-1:0]   mean_value;
	logic [plma_pkg::CNTOUT_W-1:0] pixel_count;
	logic [plma_pkg::LABEL_W-1:0]  largest_label;
	logic [plma_pkg::STAT_W-1:0]   status;

	per_label_mean_accumulator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .region_label(region_label), .probability(probability),
		.done(done), .mean_value(mean_value), .pixel_count(pixel_count),
		.largest_label(largest_label), .status(status)
	);

	always #2 clk = ~clk;

	// Mirror of the label memory and the largest-label register
	logic [39:0]                  sum_tbl [NUM_LBL];
	logic [CNT_BITS-1:0]          cnt_tbl [NUM_LBL];
	logic [plma_pkg::LABEL_W-1:0] top_label = '0;

	pixel_cmd_t  pixel_q[$];
	label_stat_t pending_stats[$];
	int beats_offered = 0;
	int beats_taken   = 0;
	int total_items   = 0;
	int mismatch_count = 0;
	int results_seen  = 0;
	int n_accum = 0, n_mean = 0, n_empty = 0;
	int n_range = 0, n_frame = 0, n_spare = 0;
	logic [plma_pkg::LABEL_W-1:0] label_pool [POOL_SIZE];

	initial begin
		for (int i = 0; i < NUM_LBL; i++) begin
			sum_tbl[i] = '0;
			cnt_tbl[i] = '0;
		end
	end

	// Work out the stats beat for one command and advance the mirror state
	function automatic label_stat_t predict_label_stats(input pixel_cmd_t c);
		label_stat_t r;
		logic        in_range;
		int          idx;
		in_range = c.label >= 1 && c.label <= NUM_LBL;
		idx = in_range ? int'(c.label) - 1 : 0;
		r = '0;
		r.status = plma_pkg::STAT_OK;
		if ((c.func == plma_pkg::FUNC_ACCUM || c.func == plma_pkg::FUNC_READ) &&
				!in_range) begin
			r.status = plma_pkg::STAT_RANGE;
			n_range++;
		end else if (c.func == plma_pkg::FUNC_ACCUM) begin
			if (cnt_tbl[idx] != '1) begin
				cnt_tbl[idx] = cnt_tbl[idx] + 1'b1;
				sum_tbl[idx] = sum_tbl[idx] + c.prob;
			end
			if (c.label > top_label)
				top_label = c.label;
			n_accum++;
		end else if (c.func == plma_pkg::FUNC_READ) begin
			if (cnt_tbl[idx] == '0) begin
				r.status = plma_pkg::STAT_EMPTY;
				n_empty++;
			end else begin
				r.mean  = plma_pkg::MEAN_W'(sum_tbl[idx] / cnt_tbl[idx]);
				r.count = plma_pkg::CNTOUT_W'(cnt_tbl[idx]);
				sum_tbl[idx] = '0;
				cnt_tbl[idx] = '0;
				n_mean++;
			end
		end else if (c.func == plma_pkg::FUNC_FRAME) begin
			top_label = '0;
			n_frame++;
		end else begin
			n_spare++;
		end
		r.largest = top_label;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [39:0] want,
			input logic [39:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, fname, want, got);
		end
	endtask

	// Sender idle rate per phase: light, heavy, none
	function automatic int sender_idle_pct();
		if (beats_offered < total_items / 3)
			return 14;
		if (beats_offered < (2 * total_items) / 3)
			return 78;
		return 0;
	endfunction

	function automatic logic [plma_pkg::PROB_W-1:0] pick_prob();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '1;
		if (r < 20)
			return '0;
		return plma_pkg::PROB_W'($urandom);
	endfunction

	function automatic logic [plma_pkg::LABEL_W-1:0] any_valid_label();
		return plma_pkg::LABEL_W'($urandom_range(NUM_LBL, 1));
	endfunction

	function automatic logic [plma_pkg::LABEL_W-1:0] pool_label();
		return label_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	task automatic push_cmd(input logic [plma_pkg::FUNC_W-1:0] f,
			input logic [plma_pkg::LABEL_W-1:0] l,
			input logic [plma_pkg::PROB_W-1:0] p);
		pixel_cmd_t c;
		c.func  = f;
		c.label = l;
		c.prob  = p;
		pixel_q.push_back(c);
	endtask

	// Driver: offer the next command at the falling edge once the last one was taken
	always @(negedge clk) begin : drive_beat
		pixel_cmd_t nxt;
		if (arst_n && (!start || beats_taken == beats_offered)) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
				nxt = pixel_q.pop_front();
				func         <= nxt.func;
				region_label <= nxt.label;
				probability  <= nxt.prob;
				start        <= 1'b1;
				beats_offered++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check result beats, then predict for the accepted command
	always @(posedge clk) begin : watch_beats
		label_stat_t want;
		pixel_cmd_t  took;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (pending_stats.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected beat, expected none, actual %0h/%0h/%0h/%0h",
						$time, mean_value, pixel_count, largest_label, status);
				end else begin
					want = pending_stats.pop_front();
					check_field("mean_value", want.mean, mean_value);
					check_field("pixel_count", want.count, pixel_count);
					check_field("largest_label", want.largest, largest_label);
					check_field("status", want.status, status);
				end
			end
			if (start && !busy) begin
				took.func  = func;
				took.label = region_label;
				took.prob  = probability;
				pending_stats.push_back(predict_label_stats(took));
				beats_taken++;
			end
		end
	end

	// Watchdog
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: timeout with %0d commands and %0d results outstanding",
				$time, pixel_q.size(), pending_stats.size());
			$display("per_label_mean_accumulator_top regression: fail");
			$finish;
		end
	end

	initial begin : run_test
		int r;
		// Directed: extremes, every function, every status
		push_cmd(plma_pkg::FUNC_FRAME, 16'd0, 16'h0000);
		push_cmd(plma_pkg::FUNC_READ, 16'd1, 16'h0000);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd1, 16'hFFFF);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd1, 16'h0000);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd1024, 16'h8001);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd0, 16'hFFFF);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd1025, 16'h1234);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'hFFFF, 16'hFFFF);
		push_cmd(plma_pkg::FUNC_READ, 16'd0, 16'h0000);
		push_cmd(plma_pkg::FUNC_READ, 16'hFFFF, 16'hFFFF);
		push_cmd(FUNC_SPARE, 16'hFFFF, 16'hFFFF);
		push_cmd(plma_pkg::FUNC_READ, 16'd1, 16'hAAAA);
		push_cmd(plma_pkg::FUNC_READ, 16'd1, 16'h0000);
		push_cmd(plma_pkg::FUNC_READ, 16'd1024, 16'h0000);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd512, 16'h5555);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd512, 16'h5556);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd512, 16'h0001);
		push_cmd(plma_pkg::FUNC_READ, 16'd512, 16'h0000);
		push_cmd(plma_pkg::FUNC_FRAME, 16'hFFFF, 16'hFFFF);
		push_cmd(FUNC_SPARE, 16'd0, 16'h0000);
		push_cmd(plma_pkg::FUNC_ACCUM, 16'd7, 16'h7FFF);
		push_cmd(plma_pkg::FUNC_READ, 16'd7, 16'h0000);

		// Random: mostly pixels on a small set of labels so reads find data
		label_pool[0] = 16'd1;
		label_pool[1] = plma_pkg::LABEL_W'(NUM_LBL);
		for (int i = 2; i < POOL_SIZE; i++)
			label_pool[i] = any_valid_label();
		for (int i = 0; i < RAND_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				push_cmd(plma_pkg::FUNC_ACCUM, pool_label(), pick_prob());
			else if (r < 78)
				push_cmd(plma_pkg::FUNC_ACCUM, any_valid_label(), pick_prob());
			else if (r < 86)
				push_cmd(plma_pkg::FUNC_READ, pool_label(),
					plma_pkg::PROB_W'($urandom));
			else if (r < 88)
				push_cmd(plma_pkg::FUNC_READ, any_valid_label(),
					plma_pkg::PROB_W'($urandom));
			else if (r < 91)
				push_cmd(plma_pkg::FUNC_FRAME, plma_pkg::LABEL_W'($urandom),
					plma_pkg::PROB_W'($urandom));
			else if (r < 93)
				push_cmd(FUNC_SPARE, plma_pkg::LABEL_W'($urandom),
					plma_pkg::PROB_W'($urandom));
			else
				push_cmd(plma_pkg::FUNC_W'($urandom_range(3)),
					plma_pkg::LABEL_W'($urandom), plma_pkg::PROB_W'($urandom));
		end
		total_items = pixel_q.size();

		// Hold reset, release away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain stimulus, then outstanding results, then let stray beats show
		while (pixel_q.size() != 0 || beats_taken != beats_offered)
			@(posedge clk);
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d commands, %0d results: %0d pixels, %0d mean reads,",
			beats_taken, results_seen, n_accum, n_mean);
		$display("%0d empty reads, %0d out-of-range, %0d frames, %0d spare; %0d mismatches",
			n_empty, n_range, n_frame, n_spare, mismatch_count);
		if (mismatch_count == 0)
			$display("per_label_mean_accumulator_top regression: pass");
		else
			$display("per_label_mean_accumulator_top regression: fail");
		$finish;
	end

endmodule

>>> sim.f
design/plma_pkg.sv
design/plma_ctrl.sv
design/plma_dp.sv
design/per_label_mean_accumulator_top.sv
test/per_label_mean_accumulator_top_tb.sv
